// File: hdl/lru_page_replacement_assert.svh
// Assertion macros shared by the LRU page replacement RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lru_pkg.sv
// Package for the LRU page replacement block: sequencer states, the control
// bundle from the sequencer to the datapath, and fixed port widths. No dependencies.
`default_nettype none

package lru_pkg;

    localparam int PAGE_IN_W   = 20;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 2;
    localparam int FIDX_W      = 3;
    localparam int TOTAL_W     = 16;
    localparam int CFG_W       = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_TOUCH,
        ST_DONE
    } lru_state_t;

    typedef struct packed {
        logic accept;       // item taken this cycle
        logic scan_issue;   // frame table read issued
        logic scan_data;    // frame table read data present
        logic decide;       // hit/fill/evict choice made this cycle
        logic touch_issue;  // rank read issued
        logic touch_data;   // rank read data present, write back
        logic load_out;     // result moves to the output register
    } lru_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/lru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/lru_ctrl.sv
// Sequencer for the LRU page replacement block: walks the frames once to
// search and once to update ranks. Depends on lru_pkg and the assertion header.
`default_nettype none

`include "lru_page_replacement_assert.svh"

module lru_ctrl #(
    parameter int MAX_FRAMES = 8
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic                                     out_busy,
    input  wire logic [$clog2(MAX_FRAMES+1)-1:0]          n,
    output lru_pkg::lru_ctrl_t                            ctrl,
    output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] issue_idx,
    output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] data_idx
);
    import lru_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    lru_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] didx_reg, didx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            didx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            didx_reg  <= didx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        didx_next  = didx_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN, ST_TOUCH:
            begin
                if (state_reg == ST_SCAN)
                begin
                    ctrl.scan_issue = (cnt_reg < n);
                    ctrl.scan_data  = (cnt_reg != '0);
                end
                else
                begin
                    ctrl.touch_issue = (cnt_reg < n);
                    ctrl.touch_data  = (cnt_reg != '0);
                end
                didx_next = cnt_reg[IDX_W-1:0];
                if (cnt_reg == n)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == ST_SCAN) ? ST_DECIDE : ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DECIDE:
            begin
                ctrl.decide = 1'b1;
                cnt_next    = '0;
                state_next  = ST_TOUCH;
            end
            ST_DONE:
            begin
                if (!out_busy)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign issue_idx = cnt_reg[IDX_W-1:0];
    assign data_idx  = didx_reg;

    `LRU_ASSERT_NOW(a_cnt_range, (state_reg == ST_SCAN) || (state_reg == ST_TOUCH), cnt_reg <= n, "frame counter ran past the active frame count")
    `LRU_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, (state_reg == ST_SCAN) && (cnt_reg == '0), "accepted item did not start a search from frame zero")
    `LRU_ASSERT_NEXT(a_decide_touch, ctrl.decide, (state_reg == ST_TOUCH) && (cnt_reg == '0), "rank update did not follow the decision")

endmodule

`default_nettype wire

// File: hdl/lru_page_replacement.sv
// LRU page replacement block, top level.
// Channels: s_axis takes one page reference per item; tdata[19:0] holds the
// page number and tuser[0] the start-of-run flag, which clears every frame and
// both totals before the reference is looked up. m_axis gives one result per
// item: tuser[0] hit, tuser[1] eviction, tdata carries the frame, the evicted
// page and the saturating hit and fault totals. cfg_we/cfg_wdata set the
// number of frames in use (0 acts as 1, values above MAX_FRAMES as MAX_FRAMES);
// write it only while the block is idle.
// Flow: one item is in flight at a time; a new item is accepted only once the
// previous result has moved to the output register. The pace is set by the
// single read port of the frame and rank tables: one pass reads every frame to
// search it, and a second pass rewrites every rank.
// Reset empties all frames, zeroes the totals and sets four frames in use.
// If the receiver stalls, the finished result waits in the output register and
// the next item is still accepted and processed; its result waits in turn until
// the output register frees up.
`default_nettype none

`include "lru_page_replacement_assert.svh"

module lru_page_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 20
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration: frames_in_use
    input  wire logic                               cfg_we,
    input  wire logic [lru_pkg::CFG_W-1:0]          cfg_wdata,
    // Input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [lru_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [19:0] page_number, rest zero
    input  wire logic [0:0]                         s_axis_tuser,  // [0] start_run
    // Result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [2:0] frame_index, [22:3] evicted_page, [38:23] hit_total, [54:39] fault_total
    output logic [lru_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic [lru_pkg::OUT_TUSER_W-1:0]         m_axis_tuser   // [0] is_hit, [1] evicted_valid
);
    import lru_pkg::*;

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int RANK_W = IDX_W;
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_FRAMES - 1);

    // Configuration and active frame count.
    logic [CFG_W-1:0]  frames_reg;
    logic [CNT_W-1:0]  n_act;

    // Control.
    lru_ctrl_t         ctrl;
    logic [IDX_W-1:0]  issue_idx, data_idx;
    logic              out_busy;

    // Frame state.
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [TOTAL_W-1:0]    hit_total_reg, fault_total_reg;
    logic [PAGE_BITS-1:0]  page_rd;
    logic [RANK_W-1:0]     rank_rd, rank_new;
    logic                  valid_k;

    // Per-item working registers.
    logic [PAGE_BITS-1:0]  page_reg;
    logic                  hit_found_reg, empty_found_reg;
    logic [IDX_W-1:0]      hit_idx_reg, empty_idx_reg, vic_idx_reg, f_reg;
    logic [RANK_W-1:0]     hit_rank_reg, vic_rank_reg, old_rank_reg;
    logic [PAGE_BITS-1:0]  vic_page_reg;
    logic                  old_inf_reg, evict_reg;
    logic [PAGE_IN_W-1:0]  ev_page_reg;
    logic [IDX_W-1:0]      f_sel;

    // Shared rank comparator: victim search during the scan, recency test
    // during the rank update.
    logic [RANK_W-1:0]     cmp_a, cmp_b;
    logic                  cmp_gt;

    // Output register.
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;

    always_comb
    begin
        if (frames_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (32'(frames_reg) > 32'(MAX_FRAMES))
        begin
            n_act = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            n_act = CNT_W'(frames_reg);
        end
    end

    assign out_busy = out_valid_reg && !m_axis_tready;

    lru_ctrl #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_busy  (out_busy),
        .n         (n_act),
        .ctrl      (ctrl),
        .issue_idx (issue_idx),
        .data_idx  (data_idx)
    );

    // Page held by each frame; only frames marked valid are ever trusted.
    lru_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_page_ram (
        .clk   (clk),
        .we    (ctrl.decide && !hit_found_reg),
        .waddr (f_sel),
        .wdata (page_reg),
        .raddr (issue_idx),
        .rdata (page_rd)
    );

    // Recency rank of each frame; a frame gets rank zero when it becomes valid,
    // so ranks of empty frames never matter.
    lru_ram #(
        .WIDTH (RANK_W),
        .DEPTH (MAX_FRAMES)
    ) u_rank_ram (
        .clk   (clk),
        .we    (ctrl.touch_data),
        .waddr (data_idx),
        .wdata (rank_new),
        .raddr (issue_idx),
        .rdata (rank_rd)
    );

    assign valid_k = valid_reg[data_idx];

    always_comb
    begin
        if (ctrl.touch_data)
        begin
            cmp_a = old_rank_reg;
            cmp_b = rank_rd;
        end
        else
        begin
            cmp_a = rank_rd;
            cmp_b = vic_rank_reg;
        end
        cmp_gt = (cmp_a > cmp_b);
    end

    // A hit takes the matching frame, a fault the first empty frame, else the
    // oldest frame found by the scan.
    always_comb
    begin
        if (hit_found_reg)
        begin
            f_sel = hit_idx_reg;
        end
        else if (empty_found_reg)
        begin
            f_sel = empty_idx_reg;
        end
        else
        begin
            f_sel = vic_idx_reg;
        end
    end

    // Frames younger than the used frame age by one, saturating at the top
    // rank; a freshly filled frame counts as older than every other frame.
    always_comb
    begin
        rank_new = rank_rd;
        if (data_idx == f_reg)
        begin
            rank_new = '0;
        end
        else if (valid_k && (old_inf_reg || cmp_gt) && (rank_rd != RANK_TOP))
        begin
            rank_new = rank_rd + 1'b1;
        end
    end

    // Control state: configuration, valid bits, totals, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg      <= CFG_RESET;
            valid_reg       <= '0;
            hit_total_reg   <= '0;
            fault_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frames_reg <= cfg_wdata;
            end
            if (ctrl.accept && s_axis_tuser[0])
            begin
                valid_reg       <= '0;
                hit_total_reg   <= '0;
                fault_total_reg <= '0;
            end
            if (ctrl.decide)
            begin
                valid_reg[f_sel] <= 1'b1;
                if (hit_found_reg)
                begin
                    if (hit_total_reg != '1)
                    begin
                        hit_total_reg <= hit_total_reg + 1'b1;
                    end
                end
                else if (fault_total_reg != '1)
                begin
                    fault_total_reg <= fault_total_reg + 1'b1;
                end
            end
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the item in flight and the output payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            page_reg        <= PAGE_BITS'(s_axis_tdata[PAGE_IN_W-1:0]);
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        if (ctrl.scan_data)
        begin
            if (valid_k && (page_rd == page_reg) && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= data_idx;
                hit_rank_reg  <= rank_rd;
            end
            if (!valid_k && !empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
                empty_idx_reg   <= data_idx;
            end
            if ((data_idx == '0) || cmp_gt)
            begin
                vic_idx_reg  <= data_idx;
                vic_rank_reg <= rank_rd;
                vic_page_reg <= page_rd;
            end
        end
        if (ctrl.decide)
        begin
            f_reg        <= f_sel;
            old_rank_reg <= hit_found_reg ? hit_rank_reg : vic_rank_reg;
            old_inf_reg  <= !hit_found_reg && empty_found_reg;
            evict_reg    <= !hit_found_reg && !empty_found_reg;
            if (!hit_found_reg && !empty_found_reg)
            begin
                ev_page_reg <= PAGE_IN_W'(vic_page_reg);
            end
            else
            begin
                ev_page_reg <= '0;
            end
        end
        if (ctrl.load_out)
        begin
            out_data_reg <= {1'b0, fault_total_reg, hit_total_reg, ev_page_reg,
                             FIDX_W'(f_reg)};
            out_user_reg <= {evict_reg, hit_found_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `LRU_ASSERT_NOW(a_hit_no_evict, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "result reports both a hit and an eviction")
    `LRU_ASSERT_NEXT(a_used_frame_valid, ctrl.decide, valid_reg[f_reg], "frame chosen for the reference is not marked valid")
    `LRU_ASSERT_NOW(a_issue_range, ctrl.scan_issue || ctrl.touch_issue, CNT_W'(issue_idx) < n_act, "table read past the active frames")

endmodule

`default_nettype wire
